// ----- hdl/par_pkg.sv -----
// shared types, constants and arctangent table for the pivot rotation matrix
package par_pkg;

  localparam int TRIG_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_W = 22;
  localparam int ZW = 28;
  localparam int CW = 33;
  localparam int IN_W = 168;
  localparam int OUT_W = 136;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [CW-1:0] trig_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
  } geom_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/par_trig.sv -----
// angle reduction and pipelined cordic for cosine and sine
module par_trig #(
  parameter int TRIG_STEPS = par_pkg::TRIG_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [17:0]    in_angle,
  input  par_pkg::geom_t        in_geom,
  output logic                  out_valid,
  output par_pkg::trig_t        out_cos,
  output par_pkg::trig_t        out_sin,
  output par_pkg::geom_t        out_geom
);

  localparam logic signed [18:0] FULL_TURN = 19'sd92160;
  localparam logic signed [18:0] HALF_TURN = 19'sd46080;
  localparam logic signed [18:0] QUARTER_TURN = 19'sd23040;

  logic signed [18:0] r0, r1, r2;
  logic               flip_in;

  logic                          v    [0:TRIG_STEPS];
  par_pkg::trig_t                x    [0:TRIG_STEPS];
  par_pkg::trig_t                y    [0:TRIG_STEPS];
  logic signed [par_pkg::ZW-1:0] z    [0:TRIG_STEPS];
  logic                          flip [0:TRIG_STEPS];
  par_pkg::geom_t                geom [0:TRIG_STEPS];

  always_comb begin
    r0 = 19'(in_angle);
    if (r0 >= FULL_TURN) begin
      r0 = r0 - FULL_TURN;
    end else if (r0 <= -FULL_TURN) begin
      r0 = r0 + FULL_TURN;
    end
    r1 = r0;
    if (r1 >= HALF_TURN) begin
      r1 = r1 - FULL_TURN;
    end else if (r1 < -HALF_TURN) begin
      r1 = r1 + FULL_TURN;
    end
    r2 = r1;
    flip_in = 1'b0;
    if (r1 > QUARTER_TURN) begin
      r2 = r1 - HALF_TURN;
      flip_in = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2 = r1 + HALF_TURN;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= par_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= par_pkg::ZW'(r2) <<< 8;
      flip[0] <= flip_in;
      geom[0] <= in_geom;
    end
  end

  for (genvar gi = 0; gi < TRIG_STEPS; gi++) begin : g_step
    localparam logic signed [par_pkg::ZW-1:0] ANG =
      par_pkg::ZW'(par_pkg::atan_lut(5'(gi)));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[gi+1] <= 1'b0;
      end else if (en) begin
        v[gi+1] <= v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z[gi] >= 0) begin
          x[gi+1] <= x[gi] - (y[gi] >>> gi);
          y[gi+1] <= y[gi] + (x[gi] >>> gi);
          z[gi+1] <= z[gi] - ANG;
        end else begin
          x[gi+1] <= x[gi] + (y[gi] >>> gi);
          y[gi+1] <= y[gi] - (x[gi] >>> gi);
          z[gi+1] <= z[gi] + ANG;
        end
        flip[gi+1] <= flip[gi];
        geom[gi+1] <= geom[gi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[TRIG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos  <= flip[TRIG_STEPS] ? -x[TRIG_STEPS] : x[TRIG_STEPS];
      out_sin  <= flip[TRIG_STEPS] ? -y[TRIG_STEPS] : y[TRIG_STEPS];
      out_geom <= geom[TRIG_STEPS];
    end
  end

endmodule

// ----- hdl/par_matrix.sv -----
// rodrigues rotation matrix entries, rounded to q16.16
module par_matrix (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  par_pkg::trig_t in_cos,
  input  par_pkg::trig_t in_sin,
  input  par_pkg::geom_t in_geom,
  output logic           out_valid,
  output par_pkg::q16_t  out_r [0:2][0:2],
  output par_pkg::geom_t out_geom
);

  function automatic par_pkg::q16_t round60(input logic signed [65:0] val);
    logic signed [65:0] tmp;
    tmp = (val + (66'sd1 <<< 43)) >>> 44;
    return tmp[31:0];
  endfunction

  logic signed [33:0] t;
  logic               v1, v2;
  logic signed [49:0] ta [0:2];
  logic signed [48:0] sa [0:2], sa2 [0:2];
  par_pkg::trig_t     c1, c2;
  par_pkg::geom_t     g1, g2;
  logic signed [65:0] q_d [0:2];
  logic signed [65:0] q01, q02, q12;
  logic signed [65:0] cs, k0, k1, k2;

  assign t = (34'sd1 <<< 30) - 34'(in_cos);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta[0] <= t * $signed(in_geom.axis_x);
      ta[1] <= t * $signed(in_geom.axis_y);
      ta[2] <= t * $signed(in_geom.axis_z);
      sa[0] <= in_sin * $signed(in_geom.axis_x);
      sa[1] <= in_sin * $signed(in_geom.axis_y);
      sa[2] <= in_sin * $signed(in_geom.axis_z);
      c1    <= in_cos;
      g1    <= in_geom;

      q_d[0] <= ta[0] * $signed(g1.axis_x);
      q_d[1] <= ta[1] * $signed(g1.axis_y);
      q_d[2] <= ta[2] * $signed(g1.axis_z);
      q01    <= ta[0] * $signed(g1.axis_y);
      q02    <= ta[0] * $signed(g1.axis_z);
      q12    <= ta[1] * $signed(g1.axis_z);
      sa2    <= sa;
      c2     <= c1;
      g2     <= g1;
    end
  end

  assign cs = 66'(c2) <<< 30;
  assign k0 = 66'(sa2[0]) <<< 15;
  assign k1 = 66'(sa2[1]) <<< 15;
  assign k2 = 66'(sa2[2]) <<< 15;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r[0][0] <= round60(cs + q_d[0]);
      out_r[1][1] <= round60(cs + q_d[1]);
      out_r[2][2] <= round60(cs + q_d[2]);
      out_r[1][0] <= round60(q01 + k2);
      out_r[0][1] <= round60(q01 - k2);
      out_r[2][0] <= round60(q02 - k1);
      out_r[0][2] <= round60(q02 + k1);
      out_r[2][1] <= round60(q12 + k0);
      out_r[1][2] <= round60(q12 - k0);
      out_geom    <= g2;
    end
  end

endmodule

// ----- hdl/par_xlate.sv -----
// translation column p - r*p with rounding and saturation, matrix hold register
module par_xlate (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  par_pkg::q16_t  in_r [0:2][0:2],
  input  par_pkg::geom_t in_geom,
  output logic           out_valid,
  output par_pkg::q16_t  out_r [0:2][0:2],
  output par_pkg::q16_t  out_tr [0:2]
);

  function automatic par_pkg::q16_t fin(input logic signed [31:0] p,
                                        input logic signed [63:0] m0,
                                        input logic signed [63:0] m1,
                                        input logic signed [63:0] m2);
    logic signed [65:0] acc;
    logic signed [65:0] rnd;
    acc = (66'(p) <<< 16) - 66'(m0) - 66'(m1) - 66'(m2);
    rnd = (acc + 66'sd32768) >>> 16;
    if (rnd > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (rnd < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return rnd[31:0];
  endfunction

  logic               v1;
  logic signed [63:0] m [0:2][0:2];
  par_pkg::q16_t      r1 [0:2][0:2];
  par_pkg::q16_t      p1 [0:2];
  par_pkg::q16_t      pin [0:2];

  assign pin[0] = in_geom.pivot_x;
  assign pin[1] = in_geom.pivot_y;
  assign pin[2] = in_geom.pivot_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m[i][j] <= in_r[i][j] * pin[j];
        end
      end
      r1    <= in_r;
      p1    <= pin;
      out_r <= r1;
      for (int i = 0; i < 3; i++) begin
        out_tr[i] <= fin(p1[i], m[i][0], m[i][1], m[i][2]);
      end
    end
  end

endmodule

// ----- hdl/pivot_axis_rotation_matrix.sv -----
// top level: pivot axis-angle rotation matrix, four row words per input word
//
// Each input word (angle, unit axis, pivot) yields the 4x4 matrix
// translate(p)*R*translate(-p) as four output words, rows 0 to 3, with
// tlast on row 3. The input side takes a word every cycle while the
// pipeline moves. The single output channel sets the sustained rate, as
// each input word leaves as four output words; the whole pipeline holds
// while the finished matrix is being sent.
module pivot_axis_rotation_matrix #(
  parameter int TRIG_STEPS = par_pkg::TRIG_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // angle_deg, axis_x, axis_y, axis_z, pivot_x, pivot_y, pivot_z
  input  logic [par_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // row_index, col0, col1, col2, col3
  output logic [par_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);

  logic           en;
  logic [1:0]     row;
  par_pkg::geom_t in_geom, t_geom, m_geom;
  logic           t_valid, mx_valid, hold_valid;
  par_pkg::trig_t t_cos, t_sin;
  par_pkg::q16_t  mx_r [0:2][0:2];
  par_pkg::q16_t  h_r [0:2][0:2];
  par_pkg::q16_t  h_tr [0:2];
  par_pkg::q16_t  c0, c1, c2, c3;

  assign en = !hold_valid || (m_tready && row == 2'd3);
  assign s_tready = en;

  assign in_geom.axis_x  = s_tdata[33:18];
  assign in_geom.axis_y  = s_tdata[49:34];
  assign in_geom.axis_z  = s_tdata[65:50];
  assign in_geom.pivot_x = s_tdata[97:66];
  assign in_geom.pivot_y = s_tdata[129:98];
  assign in_geom.pivot_z = s_tdata[161:130];

  par_trig #(.TRIG_STEPS(TRIG_STEPS)) u_trig (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready),
    .in_angle(s_tdata[17:0]),
    .in_geom(in_geom),
    .out_valid(t_valid), .out_cos(t_cos), .out_sin(t_sin), .out_geom(t_geom)
  );

  par_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t_valid), .in_cos(t_cos), .in_sin(t_sin), .in_geom(t_geom),
    .out_valid(mx_valid), .out_r(mx_r), .out_geom(m_geom)
  );

  par_xlate u_xlate (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mx_valid), .in_r(mx_r), .in_geom(m_geom),
    .out_valid(hold_valid), .out_r(h_r), .out_tr(h_tr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 2'd0;
    end else if (en) begin
      row <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      row <= row + 2'd1;
    end
  end

  always_comb begin
    c0 = '0;
    c1 = '0;
    c2 = '0;
    c3 = par_pkg::ONE_Q16;
    if (row != 2'd3) begin
      c0 = h_r[row][0];
      c1 = h_r[row][1];
      c2 = h_r[row][2];
      c3 = h_tr[row];
    end
  end

  assign m_tvalid = hold_valid;
  assign m_tlast  = (row == 2'd3);
  assign m_tdata  = {6'd0, c3, c2, c1, c0, row};

endmodule

// ----- tb/pivot_axis_rotation_matrix_test.sv -----
// testbench for the pivot rotation matrix: directed table then random words, checked by a predictor
`timescale 1ns / 1ps

module pivot_axis_rotation_matrix_test;

  localparam int RANDOM_WORDS = 105;
  localparam int DRAIN_CYCLES = par_pkg::TRIG_STEPS + 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint FULL_TURN = 92160;
  localparam longint HALF_TURN = 46080;
  localparam longint QUARTER_TURN = 23040;
  localparam longint GAIN = 652032874;

  typedef struct {
    logic signed [17:0] angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } pose_t;

  typedef struct {
    logic [1:0] row;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic last;
  } row_t;

  localparam longint ARCTAN [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [par_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [par_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;

  row_t pending_rows[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;

  pivot_axis_rotation_matrix u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic [par_pkg::IN_W-1:0] pack_pose(pose_t p);
    return {6'd0, p.pz, p.py, p.px, p.az, p.ay, p.ax, p.angle};
  endfunction

  function automatic longint round_q60(longint v);
    return (v + (64'sd1 <<< 43)) >>> 44;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_matrix(input logic [par_pkg::IN_W-1:0] w);
    longint r, x, y, z, dx, dy, c, s, t, k, acc;
    longint a[3], p[3], m[3][3];
    bit flip;
    row_t e;
    r = longint'($signed(w[17:0])) % FULL_TURN;
    flip = 0;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r < -HALF_TURN) r += FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1;
    end
    x = GAIN;
    y = 0;
    z = r * 256;
    for (int i = 0; i < par_pkg::TRIG_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    a[0] = $signed(w[33:18]);
    a[1] = $signed(w[49:34]);
    a[2] = $signed(w[65:50]);
    p[0] = $signed(w[97:66]);
    p[1] = $signed(w[129:98]);
    p[2] = $signed(w[161:130]);
    t = (64'sd1 <<< 30) - c;
    k = s * 32768;
    for (int i = 0; i < 3; i++) m[i][i] = round_q60(c * (64'sd1 <<< 30) + t * a[i] * a[i]);
    m[1][0] = round_q60(t * a[0] * a[1] + k * a[2]);
    m[0][1] = round_q60(t * a[0] * a[1] - k * a[2]);
    m[2][0] = round_q60(t * a[0] * a[2] - k * a[1]);
    m[0][2] = round_q60(t * a[0] * a[2] + k * a[1]);
    m[2][1] = round_q60(t * a[1] * a[2] + k * a[0]);
    m[1][2] = round_q60(t * a[1] * a[2] - k * a[0]);
    for (int i = 0; i < 3; i++) begin
      acc = p[i] * 65536;
      for (int j = 0; j < 3; j++) acc -= m[i][j] * p[j];
      e.row = 2'(i);
      e.c0 = m[i][0][31:0];
      e.c1 = m[i][1][31:0];
      e.c2 = m[i][2][31:0];
      e.c3 = 32'(clamp32((acc + 32768) >>> 16));
      e.last = 1'b0;
      pending_rows.push_back(e);
    end
    // bottom row is fixed
    e.row = 2'd3; e.c0 = '0; e.c1 = '0; e.c2 = '0; e.c3 = 32'h0001_0000; e.last = 1'b1;
    pending_rows.push_back(e);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && s_tvalid && s_tready) predict_matrix(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        report("unexpected word", m_tdata[31:0], 32'd0);
      end else begin
        row_t e;
        e = pending_rows.pop_front();
        if (m_tdata[1:0] != e.row) report("row_index", 32'(m_tdata[1:0]), 32'(e.row));
        if (m_tdata[33:2] != e.c0) report("col0", m_tdata[33:2], e.c0);
        if (m_tdata[65:34] != e.c1) report("col1", m_tdata[65:34], e.c1);
        if (m_tdata[97:66] != e.c2) report("col2", m_tdata[97:66], e.c2);
        if (m_tdata[129:98] != e.c3) report("col3", m_tdata[129:98], e.c3);
        if (m_tlast != e.last) report("last_row", 32'(m_tlast), 32'(e.last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pose(input pose_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_pose(p);
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    p.angle = 18'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.ax = 16'($urandom); p.ay = 16'($urandom); p.az = 16'($urandom);
    end else begin
      // axis of at most unit length along a random octant
      p.ax = 16'($urandom_range(0, 18918)); p.ay = 16'($urandom_range(0, 18918));
      p.az = 16'($urandom_range(0, 18918));
      if ($urandom_range(0, 1)) p.ax = -p.ax;
      if ($urandom_range(0, 1)) p.ay = -p.ay;
      if ($urandom_range(0, 1)) p.az = -p.az;
    end
    if ($urandom_range(0, 3) == 0) begin
      p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    end else begin
      p.px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      p.py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      p.pz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    return p;
  endfunction

  pose_t directed [15] = '{
    '{18'sd0, 16'sd32767, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{18'sd23040, 16'sd0, 16'sd0, 16'sd32767, 32'sd65536, 32'sd0, 32'sd0},
    '{-18'sd23040, 16'sd0, 16'sd32767, 16'sd0, 32'sd0, 32'sd131072, 32'sd0},
    '{18'sd46080, 16'sd32767, 16'sd0, 16'sd0, 32'sd65536, 32'sd65536, 32'sd65536},
    '{-18'sd46080, 16'sd0, 16'sd0, -16'sd32768, -32'sd65536, 32'sd0, 32'sd0},
    '{18'sd92160, 16'sd18918, 16'sd18918, 16'sd18918, 32'sd0, 32'sd0, 32'sd0},
    '{-18'sd92160, -16'sd18918, 16'sd18918, -16'sd18918, 32'sd1000, 32'sd2000, 32'sd3000},
    '{18'sd131071, 16'sd32767, 16'sd32767, 16'sd32767, 32'sd0, 32'sd0, 32'sd0},
    '{-18'sd131072, -16'sd32768, -16'sd32768, -16'sd32768, 32'sd0, 32'sd0, 32'sd0},
    '{18'sd11520, 16'sd0, 16'sd0, 16'sd0, 32'sd65536, 32'sd65536, 32'sd0},
    '{18'sd30000, 16'sd0, 16'sd0, 16'sd32767,
      32'sh7fffffff, -32'sh7fffffff - 1, 32'sh7fffffff},
    '{-18'sd60000, 16'sd23170, 16'sd23170, 16'sd0,
      -32'sh7fffffff - 1, 32'sh7fffffff, -32'sh7fffffff - 1},
    '{18'sd46079, 16'sd32767, -16'sd32768, 16'sd32767,
      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
    '{18'sd23041, 16'sd0, 16'sd32767, 16'sd0, 32'sh0000ffff, 32'shffff0001, 32'sd1},
    '{-18'sd23041, 16'sd1, -16'sd1, 16'sd1, 32'sd0, 32'sd0, 32'sd0}
  };

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_pose(directed[i]);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) no_idle = ~no_idle;
      if (n == 60) begin
        s_tvalid <= 0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      send_pose(random_pose());
    end
    s_tvalid <= 0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

endmodule

// ----- files.f -----
hdl/par_pkg.sv
hdl/par_trig.sv
hdl/par_matrix.sv
hdl/par_xlate.sv
hdl/pivot_axis_rotation_matrix.sv
tb/pivot_axis_rotation_matrix_test.sv
